### src/gld_pkg.sv
`default_nettype none

package gld_pkg;

  // fixed field and storage widths
  localparam int CODE_W            = 12;
  localparam int BUF_W             = 32;
  localparam int HELD_W            = 6;
  localparam int NFC_W             = 13;
  localparam int DEF_TABLE_DEPTH   = 4096;
  localparam int DEF_MAX_CODE_BITS = 12;
  localparam logic [3:0] MIN_CODE_RST = 4'd8;
  localparam logic [3:0] MIN_CODE_LO  = 4'd2;
  localparam logic [3:0] MIN_CODE_HI  = 4'd8;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_PULL   = 2'd1,
    REQ_START  = 2'd2,
    REQ_UNUSED = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    STAT_PIXEL      = 3'd0,
    STAT_NEED_DATA  = 3'd1,
    STAT_BYTE_OK    = 3'd2,
    STAT_BYTE_REFUSED = 3'd3,
    STAT_END        = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_FORCE       = 2'd0,
    PH_AFTER_CLEAR = 2'd1,
    PH_NORMAL      = 2'd2,
    PH_ENDED       = 2'd3
  } phase_e;

  // outcome of one code extraction step
  typedef enum logic [2:0] {
    EXT_END,
    EXT_SHORT,
    EXT_CLEAR,
    EXT_EOI,
    EXT_ROOT,
    EXT_CHAIN
  } ext_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PUSH,
    OP_START,
    OP_BAD,
    OP_POP_RD,
    OP_POP_OUT,
    OP_EXTRACT,
    OP_WALK_RD,
    OP_WALK_PUSH,
    OP_FINISH
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_OUT,
    S_EXTRACT,
    S_WALK,
    S_WALK_DATA
  } fsm_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic stack_empty;
    logic out_free;
    logic walk_more;
    ext_e ext;
  } dp_stat_t;

endpackage

`default_nettype wire

### src/gld_ctrl.sv
`default_nettype none

module gld_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [1:0]       req_type_i,
  input  wire gld_pkg::dp_stat_t stat_i,
  output gld_pkg::dp_cmd_t      cmd_o
);
  import gld_pkg::*;

  fsm_e state_q, state_d;
  fsm_e ext_next;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // where an extraction step leads
  always_comb begin
    unique case (stat_i.ext)
      EXT_CLEAR: ext_next = S_EXTRACT;
      EXT_CHAIN: ext_next = S_WALK;
      default:   ext_next = S_IDLE;
    endcase
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = !stat_i.out_free;
        if (in_valid_i && stat_i.out_free) begin
          unique case (req_e'(req_type_i))
            REQ_PUSH:  cmd_o.op = OP_PUSH;
            REQ_START: cmd_o.op = OP_START;
            REQ_PULL: begin
              if (!stat_i.stack_empty) begin
                cmd_o.op = OP_POP_RD;
                state_d  = S_POP_OUT;
              end else begin
                cmd_o.op = OP_EXTRACT;
                state_d  = ext_next;
              end
            end
            default:   cmd_o.op = OP_BAD;
          endcase
        end
      end
      S_POP_OUT: begin
        cmd_o.op = OP_POP_OUT;
        state_d  = S_IDLE;
      end
      S_EXTRACT: begin
        cmd_o.op = OP_EXTRACT;
        state_d  = ext_next;
      end
      S_WALK: begin
        if (stat_i.walk_more) begin
          cmd_o.op = OP_WALK_RD;
          state_d  = S_WALK_DATA;
        end else begin
          cmd_o.op = OP_FINISH;
          state_d  = S_IDLE;
        end
      end
      S_WALK_DATA: begin
        cmd_o.op = OP_WALK_PUSH;
        state_d  = S_WALK;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### src/gld_datapath.sv
`default_nettype none

module gld_datapath #(
  parameter int TABLE_DEPTH   = gld_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_CODE_BITS = gld_pkg::DEF_MAX_CODE_BITS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gld_pkg::dp_cmd_t  cmd_i,
  output gld_pkg::dp_stat_t      stat_o,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              cfg_we_i,
  input  wire logic [3:0]        cfg_wdata_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [2:0]             status_o,
  output logic [7:0]             pixel_index_o
);
  import gld_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int DW = AW + 1;
  localparam int CODE_SPACE  = 1 << MAX_CODE_BITS;
  localparam int TABLE_LIMIT = (TABLE_DEPTH < CODE_SPACE) ? TABLE_DEPTH : CODE_SPACE;
  localparam logic [NFC_W-1:0] LIMIT_N  = NFC_W'(TABLE_LIMIT);
  localparam logic [DW-1:0]    DEPTH_N  = DW'(TABLE_DEPTH);
  localparam logic [DW-1:0]    WALK_TOP = DW'(TABLE_DEPTH - 1);
  localparam logic [3:0]       CW_MAX   = 4'(MAX_CODE_BITS);

  // dictionary and string stack
  logic [CODE_W-1:0] prefix_mem [TABLE_DEPTH];
  logic [7:0]        suffix_mem [TABLE_DEPTH];
  logic [7:0]        stack_mem  [TABLE_DEPTH];

  logic [BUF_W-1:0]  buf_q;
  logic [HELD_W-1:0] held_q;
  logic [3:0]        cw_q;
  logic [NFC_W-1:0]  nfc_q;
  logic [CODE_W-1:0] prev_q;
  phase_e            phase_q;
  logic [7:0]        root_q;
  logic [3:0]        min_q;
  logic [3:0]        amin_q;
  logic [DW-1:0]     depth_q;
  logic [CODE_W-1:0] cur_q;
  logic [CODE_W-1:0] code_q;
  logic              oob_q;
  logic [CODE_W-1:0] pre_rd_q;
  logic [7:0]        suf_rd_q;
  logic [7:0]        stk_rd_q;
  logic              out_valid_q;
  logic [2:0]        status_q;
  logic [7:0]        pixel_q;

  logic [CODE_W-1:0] clear_w;
  logic [CODE_W-1:0] eoi_w;
  logic [BUF_W-1:0]  cw_mask;
  logic [CODE_W-1:0] code_raw;
  logic [CODE_W-1:0] code_eff;
  logic              short_w;
  ext_e              ext_w;
  logic [3:0]        amin_clamp;
  logic              walk_more;
  logic [7:0]        walk_suf;
  logic [CODE_W-1:0] walk_pre;
  logic              add_entry;
  logic [NFC_W-1:0]  nfc_inc;
  logic [NFC_W-1:0]  width_mask;
  logic              stk_we;
  logic [AW-1:0]     stk_wa;
  logic [7:0]        stk_wd;
  logic              resp_load;
  status_e           resp_status;
  logic [7:0]        resp_pixel;
  logic              out_free;

  // code extraction view of the bit buffer
  always_comb begin
    clear_w  = CODE_W'(1) << amin_q;
    eoi_w    = clear_w + CODE_W'(1);
    cw_mask  = (BUF_W'(1) << cw_q) - BUF_W'(1);
    code_raw = CODE_W'(buf_q & cw_mask);
    code_eff = (phase_q == PH_FORCE) ? clear_w : code_raw;
    short_w  = held_q < HELD_W'(cw_q);
    priority if (phase_q == PH_ENDED) ext_w = EXT_END;
    else if (short_w)                 ext_w = EXT_SHORT;
    else if (code_eff == clear_w)     ext_w = EXT_CLEAR;
    else if (code_eff == eoi_w)       ext_w = EXT_EOI;
    else if (phase_q == PH_AFTER_CLEAR) ext_w = EXT_ROOT;
    else                              ext_w = EXT_CHAIN;
  end

  // register clamp for a new image
  always_comb begin
    priority if (min_q < MIN_CODE_LO) amin_clamp = MIN_CODE_LO;
    else if (min_q > MIN_CODE_HI)     amin_clamp = MIN_CODE_HI;
    else                              amin_clamp = min_q;
  end

  // chain walk and table update helpers
  always_comb begin
    walk_more  = (cur_q >= clear_w) && (depth_q < WALK_TOP);
    walk_suf   = oob_q ? 8'd0 : suf_rd_q;
    walk_pre   = oob_q ? '0 : pre_rd_q;
    add_entry  = nfc_q < LIMIT_N;
    nfc_inc    = add_entry ? nfc_q + NFC_W'(1) : nfc_q;
    width_mask = (NFC_W'(1) << cw_q) - NFC_W'(1);
  end

  // stack write port
  always_comb begin
    stk_we = 1'b0;
    stk_wa = depth_q[AW-1:0];
    stk_wd = root_q;
    if (cmd_i.op == OP_EXTRACT && ext_w == EXT_CHAIN &&
        {1'b0, code_eff} >= nfc_q) begin
      stk_we = 1'b1;
    end
    if (cmd_i.op == OP_WALK_PUSH) begin
      stk_we = 1'b1;
      stk_wd = walk_suf;
    end
  end

  // response selection
  always_comb begin
    resp_load   = 1'b0;
    resp_status = STAT_PIXEL;
    resp_pixel  = 8'd0;
    unique case (cmd_i.op)
      OP_PUSH: begin
        resp_load   = 1'b1;
        resp_status = (held_q > HELD_W'(24)) ? STAT_BYTE_REFUSED : STAT_BYTE_OK;
      end
      OP_START: begin
        resp_load   = 1'b1;
        resp_status = STAT_BYTE_OK;
      end
      OP_BAD: begin
        resp_load   = 1'b1;
        resp_status = STAT_BYTE_REFUSED;
      end
      OP_POP_OUT: begin
        resp_load  = 1'b1;
        resp_pixel = stk_rd_q;
      end
      OP_EXTRACT: begin
        unique case (ext_w)
          EXT_END, EXT_EOI: begin
            resp_load   = 1'b1;
            resp_status = STAT_END;
          end
          EXT_SHORT: begin
            resp_load   = 1'b1;
            resp_status = STAT_NEED_DATA;
          end
          EXT_ROOT: begin
            resp_load  = 1'b1;
            resp_pixel = code_eff[7:0] & (clear_w[7:0] - 8'd1);
          end
          default: resp_load = 1'b0;
        endcase
      end
      OP_FINISH: begin
        resp_load  = 1'b1;
        resp_pixel = cur_q[7:0];
      end
      default: resp_load = 1'b0;
    endcase
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q   <= '0;
      held_q  <= '0;
      min_q   <= MIN_CODE_RST;
      amin_q  <= MIN_CODE_RST;
      cw_q    <= MIN_CODE_RST + 4'd1;
      nfc_q   <= (NFC_W'(1) << MIN_CODE_RST) + NFC_W'(2);
      prev_q  <= '0;
      phase_q <= PH_FORCE;
      root_q  <= '0;
      depth_q <= '0;
    end else begin
      if (cfg_we_i) begin
        min_q <= cfg_wdata_i;
      end
      if (stk_we) begin
        depth_q <= depth_q + DW'(1);
      end
      unique case (cmd_i.op)
        OP_PUSH: begin
          if (held_q <= HELD_W'(24)) begin
            buf_q  <= buf_q | (BUF_W'(data_byte_i) << held_q[4:0]);
            held_q <= held_q + HELD_W'(8);
          end
        end
        OP_START: begin
          amin_q  <= amin_clamp;
          buf_q   <= '0;
          held_q  <= '0;
          cw_q    <= amin_clamp + 4'd1;
          nfc_q   <= (NFC_W'(1) << amin_clamp) + NFC_W'(2);
          prev_q  <= '0;
          phase_q <= PH_FORCE;
          root_q  <= '0;
          depth_q <= '0;
        end
        OP_POP_RD: depth_q <= depth_q - DW'(1);
        OP_EXTRACT: begin
          if (ext_w != EXT_END && ext_w != EXT_SHORT) begin
            buf_q  <= buf_q >> cw_q;
            held_q <= held_q - HELD_W'(cw_q);
          end
          unique case (ext_w)
            EXT_CLEAR: begin
              cw_q    <= amin_q + 4'd1;
              nfc_q   <= NFC_W'(clear_w) + NFC_W'(2);
              phase_q <= PH_AFTER_CLEAR;
            end
            EXT_EOI: phase_q <= PH_ENDED;
            EXT_ROOT: begin
              root_q  <= code_eff[7:0] & (clear_w[7:0] - 8'd1);
              prev_q  <= code_eff & (clear_w - CODE_W'(1));
              phase_q <= PH_NORMAL;
            end
            default: phase_q <= phase_q;
          endcase
        end
        OP_FINISH: begin
          root_q <= cur_q[7:0];
          prev_q <= code_q;
          nfc_q  <= nfc_inc;
          if (nfc_inc > width_mask && cw_q < CW_MAX) begin
            cw_q <= cw_q + 4'd1;
          end
        end
        default: buf_q <= buf_q;
      endcase
    end
  end

  // chain cursor and saved code
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EXTRACT && ext_w == EXT_CHAIN) begin
      code_q <= code_eff;
      cur_q  <= ({1'b0, code_eff} >= nfc_q) ? prev_q : code_eff;
    end else if (cmd_i.op == OP_WALK_PUSH) begin
      cur_q <= walk_pre;
    end
  end

  // dictionary memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_FINISH && add_entry) begin
      prefix_mem[nfc_q[AW-1:0]] <= prev_q;
      suffix_mem[nfc_q[AW-1:0]] <= cur_q[7:0];
    end
    if (cmd_i.op == OP_WALK_RD) begin
      pre_rd_q <= prefix_mem[cur_q[AW-1:0]];
      suf_rd_q <= suffix_mem[cur_q[AW-1:0]];
      oob_q    <= {1'b0, cur_q} >= NFC_W'(TABLE_DEPTH);
    end
  end

  // string stack memory
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= stk_wd;
    end
    if (cmd_i.op == OP_POP_RD) begin
      stk_rd_q <= stack_mem[stk_wa - AW'(1)];
    end
  end

  // result register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_load) begin
      status_q <= resp_status;
      pixel_q  <= resp_pixel;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign pixel_index_o      = pixel_q;
  assign stat_o.stack_empty = (depth_q == '0);
  assign stat_o.out_free    = out_free;
  assign stat_o.walk_more   = walk_more;
  assign stat_o.ext         = ext_w;

`ifndef ASSERT_OFF
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_N) else $error("stack depth beyond table depth");
  a_resp_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_load |-> out_free) else $error("result loaded over a pending transfer");
  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw_q >= 4'd3) && (cw_q <= CW_MAX)) else $error("code width out of range");
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HELD_W'(BUF_W)) else $error("bit count beyond buffer");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_POP_RD) |-> (depth_q != '0)) else $error("pop from empty stack");
`endif

endmodule

`default_nettype wire

### src/gif_lzw_decoder_core.sv
`default_nettype none

// GIF LZW decoder: push compressed bytes (req 0), pull one colour index per
// pull (req 1), start a new image (req 2); each accepted item gives one result.
// Push, start and unused requests answer in the cycle after they are taken. A
// pull that finds decoded indices on the string stack answers after one stack
// memory read. A pull with an empty stack takes one extraction step per code
// (clear codes chain within the pull); a code that goes through the dictionary
// adds a registered read of the dictionary memories for each prefix chain step
// and a closing step that adds the table entry; a code that expands to n
// indices returns its first index and leaves the other n-1 on the string stack
// for later pulls. One item is in work at a time; the next is taken as soon as
// the result register is free or its transfer completes.
// The minimum code size register takes effect at the next start request.
module gif_lzw_decoder_core #(
  parameter int TABLE_DEPTH   = gld_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_CODE_BITS = gld_pkg::DEF_MAX_CODE_BITS
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] req_type_i,
  input  wire logic [7:0] data_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      status_o,
  output logic [7:0]      pixel_index_o
);
  import gld_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  gld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // buffer, dictionary, stack and result register
  gld_datapath #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .data_byte_i   (data_byte_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .pixel_index_o (pixel_index_o)
  );

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import gld_pkg::*;

  localparam int DICT_SIZE   = 4096;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 40000;

  typedef struct {
    status_e    st;
    logic [7:0] px;
  } pixel_result_t;

  // dut ports
  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [3:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] req_type_i;
  logic [7:0] data_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] status_o;
  logic [7:0] pixel_index_o;

  gif_lzw_decoder_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .pixel_index_o(pixel_index_o)
  );

  // decoder prediction state
  logic [11:0] dict_prefix [DICT_SIZE];
  logic [7:0]  dict_suffix [DICT_SIZE];
  logic [7:0]  pix_stack [DICT_SIZE];
  logic [12:0] stk_depth;
  logic [31:0] bitbuf;
  logic [5:0]  nbits;
  logic [3:0]  cwidth;
  logic [12:0] next_code;
  logic [11:0] last_code;
  phase_e      phase;
  logic [7:0]  root_pix;
  logic [3:0]  cfg_min;
  logic [3:0]  act_min;

  pixel_result_t pixel_results_q[$];

  // stream encoder state
  logic [7:0] img_bytes[$];
  logic [63:0] bit_acc;
  int acc_n, g_min, g_w, g_nfc;
  bit g_first, g_ac;

  int  n_errors;
  int  n_sent;
  int  hold_gen, hold_seen, hold_left;
  bit  tx_idle_en, rx_idle_en;
  int  quiet_cycles;

  // clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void restart_image();
    act_min = (cfg_min < MIN_CODE_LO) ? MIN_CODE_LO :
              (cfg_min > MIN_CODE_HI) ? MIN_CODE_HI : cfg_min;
    stk_depth = '0;
    bitbuf    = '0;
    nbits     = '0;
    cwidth    = act_min + 4'd1;
    next_code = 13'((1 << act_min) + 2);
    last_code = '0;
    phase     = PH_FORCE;
    root_pix  = '0;
  endfunction

  function automatic void stack_pixel(input logic [7:0] v);
    if (stk_depth < DICT_SIZE) begin
      pix_stack[stk_depth] = v;
      stk_depth++;
    end
  endfunction

  function automatic void decode_pull(output status_e st, output logic [7:0] px);
    int clr, code, cur;
    clr = 1 << act_min;
    st = STAT_PIXEL;
    px = '0;
    if (stk_depth > 0) begin
      stk_depth--;
      px = pix_stack[stk_depth];
      return;
    end
    while (1) begin
      if (phase == PH_ENDED) begin
        st = STAT_END;
        return;
      end
      if (nbits < cwidth) begin
        st = STAT_NEED_DATA;
        return;
      end
      code   = int'(bitbuf & ((32'd1 << cwidth) - 32'd1));
      bitbuf = bitbuf >> cwidth;
      nbits  = nbits - cwidth;
      if (phase == PH_FORCE) code = clr;
      // clear code: keep decoding in the same pull
      if (code == clr) begin
        cwidth    = act_min + 4'd1;
        next_code = 13'(clr + 2);
        phase     = PH_AFTER_CLEAR;
        continue;
      end
      if (code == clr + 1) begin
        phase = PH_ENDED;
        st = STAT_END;
        return;
      end
      // first code after clear is taken as a root
      if (phase == PH_AFTER_CLEAR) begin
        code      = code & (clr - 1);
        root_pix  = 8'(code);
        last_code = 12'(code);
        phase     = PH_NORMAL;
        px = 8'(code);
        return;
      end
      // kwkwk and codes beyond the table
      if (code >= next_code) begin
        stack_pixel(root_pix);
        cur = last_code;
      end else begin
        cur = code;
      end
      while (cur >= clr && stk_depth + 1 < DICT_SIZE) begin
        stack_pixel(dict_suffix[cur]);
        cur = dict_prefix[cur];
      end
      cur = cur & 8'hff;
      stack_pixel(8'(cur));
      if (next_code < DICT_SIZE) begin
        dict_prefix[next_code] = last_code;
        dict_suffix[next_code] = 8'(cur);
        next_code++;
      end
      root_pix  = 8'(cur);
      last_code = 12'(code);
      if (next_code > (1 << cwidth) - 1 && cwidth < 12) cwidth++;
      stk_depth--;
      px = pix_stack[stk_depth];
      return;
    end
  endfunction

  function automatic void lzw_predict(input req_e req, input logic [7:0] b,
                                      output status_e st, output logic [7:0] px);
    px = '0;
    case (req)
      REQ_PUSH: begin
        if (nbits > 24) begin
          st = STAT_BYTE_REFUSED;
        end else begin
          bitbuf = bitbuf | (32'(b) << nbits);
          nbits  = nbits + 6'd8;
          st = STAT_BYTE_OK;
        end
      end
      REQ_PULL: decode_pull(st, px);
      REQ_START: begin
        restart_image();
        st = STAT_BYTE_OK;
      end
      default: st = STAT_BYTE_REFUSED;
    endcase
  endfunction

  // ---------------------------------------------------------------- encoder
  function automatic void gen_put(input int code);
    int clr;
    clr = 1 << g_min;
    bit_acc = bit_acc | (64'(code) << acc_n);
    acc_n += g_w;
    while (acc_n >= 8) begin
      img_bytes.push_back(bit_acc[7:0]);
      bit_acc = bit_acc >> 8;
      acc_n -= 8;
    end
    if (g_first || code == clr) begin
      g_first = 1'b0;
      g_w     = g_min + 1;
      g_nfc   = clr + 2;
      g_ac    = 1'b1;
    end else if (code == clr + 1) begin
      // end of information, nothing to track
    end else if (g_ac) begin
      g_ac = 1'b0;
    end else begin
      if (g_nfc < DICT_SIZE) g_nfc++;
      if (g_nfc > (1 << g_w) - 1 && g_w < 12) g_w++;
    end
  endfunction

  function automatic void stream_begin();
    img_bytes.delete();
    bit_acc = '0;
    acc_n   = 0;
    g_min   = (cfg_min < MIN_CODE_LO) ? MIN_CODE_LO :
              (cfg_min > MIN_CODE_HI) ? MIN_CODE_HI : cfg_min;
    g_w     = g_min + 1;
    g_first = 1'b1;
    g_ac    = 1'b0;
  endfunction

  function automatic void stream_end();
    if (acc_n > 0) img_bytes.push_back(bit_acc[7:0]);
  endfunction

  function automatic int pick_code(input bit fill_mode);
    int clr, top, r;
    clr = 1 << g_min;
    top = (1 << g_w) - 1;
    r = $urandom_range(0, 99);
    if (fill_mode) begin
      if (r < 95 || g_nfc <= clr + 2 || g_ac) return $urandom_range(0, clr - 1);
      return $urandom_range(clr + 2, g_nfc - 1);
    end
    if (g_ac) begin
      if (r < 10 && top >= clr + 2) return $urandom_range(clr + 2, top);
      return $urandom_range(0, clr - 1);
    end
    if (r < 4) return clr;
    if (r < 12 && g_nfc <= top) return g_nfc;
    if (r < 55 && g_nfc > clr + 2) return $urandom_range(clr + 2, g_nfc - 1);
    return $urandom_range(0, clr - 1);
  endfunction

  // well-formed image of random codes; optionally cut short
  function automatic void build_image(input int ncodes, input bit with_eoi,
                                      input bit fill_mode);
    int clr, top;
    stream_begin();
    clr = 1 << g_min;
    gen_put(($urandom_range(0, 3) == 0) ? $urandom_range(0, (1 << g_w) - 1) : clr);
    for (int i = 0; i < ncodes; i++) begin
      top = (1 << g_w) - 1;
      // code past the table end, followed by a clear so it is never chained
      if (!fill_mode && !g_ac && g_nfc + 1 <= top && $urandom_range(0, 49) == 0) begin
        gen_put($urandom_range(g_nfc + 1, top));
        gen_put(clr);
      end else begin
        gen_put(pick_code(fill_mode));
      end
    end
    if (with_eoi) gen_put(clr + 1);
    stream_end();
  endfunction

  // ---------------------------------------------------------------- driving
  task automatic send_req(input req_e req, input logic [7:0] b, output status_e st);
    logic [7:0] px;
    if (tx_idle_en && $urandom_range(0, 99) < 13) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    lzw_predict(req, b, st, px);
    pixel_results_q.push_back('{st, px});
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    n_sent++;
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pixel_results_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_min_code(input logic [3:0] v);
    wait_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_min = v;
  endtask

  // start, then mix pushes and pulls until the image ends or runs dry
  task automatic run_image(input bit pause_mid);
    status_e st, junk;
    logic [7:0] b;
    send_req(REQ_START, 8'($urandom), st);
    while (!(st == STAT_END || (st == STAT_NEED_DATA && img_bytes.size() == 0))) begin
      if ($urandom_range(0, 99) == 0) send_req(REQ_UNUSED, 8'($urandom), junk);
      if (pause_mid && $urandom_range(0, 39) == 0) wait_drain();
      if (img_bytes.size() > 0 && (st == STAT_NEED_DATA || $urandom_range(0, 3) == 0)) begin
        b = img_bytes.pop_front();
        send_req(REQ_PUSH, b, st);
        if (st == STAT_BYTE_REFUSED) img_bytes.push_front(b);
      end else begin
        send_req(REQ_PULL, 8'($urandom), st);
      end
    end
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    status_e st;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    write_min_code(4'd2);
    // pull with nothing buffered, unused request
    send_req(REQ_START, 8'h00, st);
    send_req(REQ_PULL, 8'hff, st);
    send_req(REQ_UNUSED, 8'h5a, st);
    // forced first code, bad root, kwkwk, code past table, clear, end
    stream_begin();
    gen_put(7);
    gen_put(6);
    gen_put(1);
    gen_put(7);
    gen_put(12);
    gen_put(4);
    gen_put(3);
    gen_put(3);
    gen_put(6);
    gen_put(5);
    stream_end();
    run_image(1'b0);
    // end repeats, pushes after end until the buffer refuses
    send_req(REQ_PULL, 8'h00, st);
    repeat (5) send_req(REQ_PUSH, 8'hff, st);
    send_req(REQ_PUSH, 8'h00, st);
    send_req(REQ_PULL, 8'h00, st);
    // widest roots at the largest code size
    write_min_code(4'd8);
    stream_begin();
    gen_put(256);
    gen_put(0);
    gen_put(255);
    gen_put(258);
    gen_put(259);
    gen_put(257);
    stream_end();
    run_image(1'b0);
  endtask

  task automatic test_config_values();
    logic [3:0] vals[$] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd9, 4'd15};
    foreach (vals[i]) begin
      write_min_code(vals[i]);
      build_image($urandom_range(4, 12), 1'b1, 1'b0);
      run_image(1'b0);
    end
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    write_min_code(4'd4);
    build_image(30, 1'b1, 1'b0);
    // receiver holds off while the sender keeps offering
    hold_gen++;
    run_image(1'b0);
    build_image(20, 1'b1, 1'b0);
    run_image(1'b1);
  endtask

  task automatic test_random();
    while (n_sent < 750) begin
      if ($urandom_range(0, 2) == 0) write_min_code(4'($urandom));
      build_image($urandom_range(3, 20), $urandom_range(0, 9) != 0, 1'b0);
      run_image($urandom_range(0, 4) == 0);
    end
  endtask

  // ---------------------------------------------------------------- receiver
  initial out_stall_i = 1'b0;
  always @(negedge clk_i) begin
    if (hold_gen != hold_seen) begin
      hold_seen = hold_gen;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= rx_idle_en && ($urandom_range(0, 99) < 13);
    end
  end

  // result check
  always @(posedge clk_i) begin : check_results
    pixel_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixel_results_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected transfer: status %0d pixel %0d", status_o, pixel_index_o);
      end else begin
        want = pixel_results_q.pop_front();
        if (status_o !== want.st || pixel_index_o !== want.px) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: status exp %0d got %0d, pixel exp %0d got %0d",
                     want.st, status_o, want.px, pixel_index_o);
        end
      end
    end
  end

  // watchdog on transfers
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("[gif_lzw_decoder_core] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_PUSH;
    data_byte_i = '0;
    n_errors    = 0;
    n_sent      = 0;
    hold_gen    = 0;
    hold_seen   = 0;
    hold_left   = 0;
    quiet_cycles = 0;
    tx_idle_en  = 1'b0;
    rx_idle_en  = 1'b0;
    cfg_min     = MIN_CODE_RST;
    restart_image();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_config_values();
    test_backpressure();
    test_random();

    wait_drain();
    repeat (20) @(negedge clk_i);
    if (n_errors == 0 && pixel_results_q.size() == 0)
      $display("[gif_lzw_decoder_core] OK");
    else
      $display("[gif_lzw_decoder_core] ERROR");
    $finish;
  end

endmodule

### files.f
src/gld_pkg.sv
src/gld_ctrl.sv
src/gld_datapath.sv
src/gif_lzw_decoder_core.sv
dv/testbench.sv
